// File: rtl/gdg_pkg.sv
// Package with shared types, constants and the fixed-point ROM tables of the generator.
`timescale 1ns / 1ps

package gdg_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int STEP_ENTRIES  = TABLE_ENTRIES - 1;
    localparam int UNIFORM_BITS  = 48;
    localparam int INDEX_BITS    = 5;
    localparam int FIX_BITS      = 56;
    localparam int MUL_A_BITS    = 56;
    localparam int MUL_B_BITS    = 48;
    localparam int MUL_CHUNK     = 16;
    localparam int MUL_STEPS     = 3;
    localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;

    localparam logic [63:0] DEC_SCALE = 64'd10000000000;
    localparam logic [47:0] LCG_MUL   = 48'h0005_DEEC_E66D;
    localparam logic [47:0] LCG_ADD   = 48'h0000_0000_000B;
    localparam logic [47:0] SEED_DEFAULT = 48'h1234_ABCD_330E;
    localparam logic [31:0] SPREAD_DEFAULT = 32'h0001_0000;

    // Configuration register indexes.
    localparam logic REG_MEAN   = 1'b0;
    localparam logic REG_SPREAD = 1'b1;

    // Input actions.
    localparam logic ACT_DRAW = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef logic [FIX_BITS-1:0] fix_t;

    // One queued input transaction.
    typedef struct packed {
        logic        action;
        logic [47:0] seed;
    } gdg_item_t;

    // Sequencer states of the execution part.
    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_LCG,
        S_SPLIT,
        S_C_CHECK,
        S_C_SLOPE,
        S_C_U,
        S_C_WID,
        S_C_LIM,
        S_C_CHAIN,
        S_C_V,
        S_C_STAR_KEEP,
        S_C_STAR_NEW,
        S_T_DBL,
        S_T_MUL,
        S_T_WID,
        S_T_LIM,
        S_T_CHAIN,
        S_T_STAR,
        S_T_TU,
        S_T_TU2,
        S_SCALE,
        S_OUT
    } gdg_state_t;

    // Decimal constant in units of 1e-10 to 48 fractional bits, rounded half up.
    function automatic fix_t to_fix(input logic [63:0] v);
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] res;
        num = v << 24;
        q   = num / DEC_SCALE;
        r   = num % DEC_SCALE;
        res = (q << 24) + (((r << 24) + (DEC_SCALE / 64'd2)) / DEC_SCALE);
        return res[FIX_BITS-1:0];
    endfunction

    localparam fix_t ROM_BASE [TABLE_ENTRIES] = '{
        to_fix(64'd0), to_fix(64'd391760900), to_fix(64'd784124100),
        to_fix(64'd1177700000), to_fix(64'd1573107000), to_fix(64'd1970991000),
        to_fix(64'd2372021000), to_fix(64'd2776904000), to_fix(64'd3186394000),
        to_fix(64'd3601300000), to_fix(64'd4022501000), to_fix(64'd4450965000),
        to_fix(64'd4887764000), to_fix(64'd5334097000), to_fix(64'd5791322000),
        to_fix(64'd6260990000), to_fix(64'd6744898000), to_fix(64'd7245144000),
        to_fix(64'd7764218000), to_fix(64'd8305109000), to_fix(64'd8871466000),
        to_fix(64'd9467818000), to_fix(64'd10099900000), to_fix(64'd10775160000),
        to_fix(64'd11503490000), to_fix(64'd12298590000), to_fix(64'd13180110000),
        to_fix(64'd14177970000), to_fix(64'd15341210000), to_fix(64'd16759400000),
        to_fix(64'd18627320000), to_fix(64'd21538750000)
    };

    localparam fix_t ROM_STEP [STEP_ENTRIES] = '{
        to_fix(64'd0), to_fix(64'd0), to_fix(64'd0), to_fix(64'd0), to_fix(64'd0),
        to_fix(64'd2636843000), to_fix(64'd2425085000), to_fix(64'd2255674000),
        to_fix(64'd2116342000), to_fix(64'd1999243000), to_fix(64'd1899108000),
        to_fix(64'd1812252000), to_fix(64'd1736014000), to_fix(64'd1668419000),
        to_fix(64'd1607967000), to_fix(64'd1553497000), to_fix(64'd1504094000),
        to_fix(64'd1459026000), to_fix(64'd1417700000), to_fix(64'd1379632000),
        to_fix(64'd1344418000), to_fix(64'd1311722000), to_fix(64'd1281260000),
        to_fix(64'd1252791000), to_fix(64'd1226109000), to_fix(64'd1201036000),
        to_fix(64'd1177417000), to_fix(64'd1155119000), to_fix(64'd1134023000),
        to_fix(64'd1114027000), to_fix(64'd1095039000)
    };

    localparam fix_t ROM_CUT [STEP_ENTRIES] = '{
        to_fix(64'd7673828), to_fix(64'd23068700), to_fix(64'd38606180),
        to_fix(64'd54384540), to_fix(64'd70507000), to_fix(64'd87083960),
        to_fix(64'd104235700), to_fix(64'd122095300), to_fix(64'd140812500),
        to_fix(64'd160557900), to_fix(64'd181529000), to_fix(64'd203957300),
        to_fix(64'd228117700), to_fix(64'd254340700), to_fix(64'd283029600),
        to_fix(64'd314682200), to_fix(64'd349923300), to_fix(64'd389548300),
        to_fix(64'd434587800), to_fix(64'd486403500), to_fix(64'd546833400),
        to_fix(64'd618422200), to_fix(64'd704798300), to_fix(64'd811319500),
        to_fix(64'd946244400), to_fix(64'd1123001000), to_fix(64'd1364980000),
        to_fix(64'd1716886000), to_fix(64'd2276241000), to_fix(64'd3304980000),
        to_fix(64'd5847031000)
    };

    localparam fix_t ROM_SLOPE [STEP_ENTRIES] = '{
        to_fix(64'd392061700), to_fix(64'd393270500), to_fix(64'd395100000),
        to_fix(64'd397570300), to_fix(64'd400709300), to_fix(64'd404553300),
        to_fix(64'd409148100), to_fix(64'd414550700), to_fix(64'd420831100),
        to_fix(64'd428074800), to_fix(64'd436386300), to_fix(64'd445893200),
        to_fix(64'd456752300), to_fix(64'd469157100), to_fix(64'd483348700),
        to_fix(64'd499629800), to_fix(64'd518385900), to_fix(64'd540113800),
        to_fix(64'd565465600), to_fix(64'd595313000), to_fix(64'd630848900),
        to_fix(64'd673750300), to_fix(64'd726454400), to_fix(64'd792647100),
        to_fix(64'd878192200), to_fix(64'd993039800), to_fix(64'd1155600000),
        to_fix(64'd1404344000), to_fix(64'd1836142000), to_fix(64'd2790016000),
        to_fix(64'd7010474000)
    };

endpackage

// File: rtl/gdg_front.sv
// Front part: accepts input transactions into a short queue for the execution part.
`timescale 1ns / 1ps

module gdg_front
    import gdg_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [47:0] seed_value,
    output logic        q_valid,
    output gdg_item_t   q_item,
    input  logic        q_pop
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

    gdg_item_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                push;
    logic                pop;

    assign in_stall = (count_reg == CNT_FULL);
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{action: action, seed: seed_value};
        end
    end

endmodule

// File: rtl/gdg_mul.sv
// Shared multi-cycle multiplier: 56 by 48 bits, one 16-bit slice of b per cycle.
`timescale 1ns / 1ps

module gdg_mul
    import gdg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [MUL_A_BITS-1:0] a,
    input  logic [MUL_B_BITS-1:0] b,
    output logic                  busy,
    output logic [PROD_BITS-1:0]  product
);

    localparam int PART_BITS = MUL_A_BITS + MUL_CHUNK;

    logic [MUL_A_BITS-1:0] a_reg;
    logic [MUL_B_BITS-1:0] b_reg;
    logic [1:0]            cnt_reg;
    logic                  busy_reg;
    logic [PROD_BITS-1:0]  acc_reg;
    logic [MUL_CHUNK-1:0]  chunk;
    logic [PART_BITS-1:0]  part;
    logic [PROD_BITS-1:0]  shifted;

    assign busy    = busy_reg;
    assign product = acc_reg;

    // Select the slice of b and align its partial product.
    always_comb
    begin
        chunk   = '0;
        shifted = '0;
        unique case (cnt_reg)
            2'd0:    chunk = b_reg[15:0];
            2'd1:    chunk = b_reg[31:16];
            2'd2:    chunk = b_reg[47:32];
            default: chunk = '0;
        endcase
        part = a_reg * chunk;
        unique case (cnt_reg)
            2'd0:    shifted = {32'd0, part};
            2'd1:    shifted = {16'd0, part, 16'd0};
            2'd2:    shifted = {part, 32'd0};
            default: shifted = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 2'(MUL_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    // Operand latches and accumulator.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + shifted;
        end
    end

endmodule

// File: rtl/gdg_back.sv
// Execution part: generator state, FL5 rejection sequencer, scaling and output register.
`timescale 1ns / 1ps

module gdg_back
    import gdg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  gdg_item_t   q_item,
    output logic        q_pop,
    input  logic [31:0] mean_value,
    input  logic [31:0] spread,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sample,
    output logic        saturated
);

    localparam logic [48:0] ONE_49  = 49'h1_0000_0000_0000;
    localparam logic [47:0] HALF_48 = 48'h8000_0000_0000;
    localparam logic [4:0]  IDX_LAST = 5'(TABLE_ENTRIES - 1);
    localparam logic [4:0]  IDX_TAIL = 5'd6;

    gdg_state_t state_reg, state_next;
    gdg_state_t mret_reg, mret_next;
    gdg_state_t uret_reg, uret_next;

    logic [47:0]           seed_reg, seed_next;
    logic [47:0]           uni_reg, uni_next;
    logic [47:0]           star_reg, star_next;
    fix_t                  lim_reg, lim_next;
    fix_t                  base_reg, base_next;
    logic [47:0]           wid_reg, wid_next;
    logic [48:0]           tu_reg, tu_next;
    logic [4:0]            idx_reg, idx_next;
    logic                  neg_reg, neg_next;
    logic [MUL_A_BITS-1:0] opa_reg, opa_next;
    logic [MUL_B_BITS-1:0] opb_reg, opb_next;
    logic [31:0]           res_reg, res_next;
    logic                  sat_reg, sat_next;
    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           sample_reg;
    logic                  saturated_reg;

    logic                  mul_start;
    logic                  mul_busy;
    logic [PROD_BITS-1:0]  product;
    fix_t                  pf;
    logic [47:0]           pw;
    logic [47:0]           lcg_val;
    logic [4:0]            im1;
    logic                  out_load;

    // Requests gathered by the state logic.
    logic                  rnd_req;
    gdg_state_t            rnd_ret;
    logic                  mul_req;
    logic [MUL_A_BITS-1:0] mul_a;
    logic [MUL_B_BITS-1:0] mul_b;
    gdg_state_t            mul_ret;

    // Split of the first uniform.
    logic [48:0]           dbl;
    logic [47:0]           frac;
    logic [4:0]            idx_split;
    logic [47:0]           tu0;
    fix_t                  y_sum;
    logic signed [57:0]    sum;
    logic signed [57:0]    mag_s;

    gdg_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (opa_reg),
        .b       (opb_reg),
        .busy    (mul_busy),
        .product (product)
    );

    assign pf      = product[PROD_BITS-1:UNIFORM_BITS];
    assign pw      = pf[47:0];
    assign lcg_val = product[47:0] + LCG_ADD;
    assign im1     = idx_reg - 5'd1;
    assign y_sum   = base_reg + {8'd0, wid_reg};

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign saturated = saturated_reg;

    // Split values and the signed scaled sum.
    always_comb
    begin
        dbl = (uni_reg > HALF_48) ? ({uni_reg, 1'b0} - ONE_49) : {uni_reg, 1'b0};
        idx_split = (dbl[48:43] > 6'(TABLE_ENTRIES - 1)) ? IDX_LAST : dbl[47:43];
        frac = {dbl[42:0], 5'd0};
        tu0  = (frac == '0) ? 48'd32 : frac;
        mag_s = $signed({2'b00, pf});
        sum  = (neg_reg ? -mag_s : mag_s) + 58'(signed'(mean_value));
    end

    // Sequencer next state and datapath.
    always_comb
    begin
        state_next     = state_reg;
        mret_next      = mret_reg;
        uret_next      = uret_reg;
        seed_next      = seed_reg;
        uni_next       = uni_reg;
        star_next      = star_reg;
        lim_next       = lim_reg;
        base_next      = base_reg;
        wid_next       = wid_reg;
        tu_next        = tu_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        res_next       = res_reg;
        sat_next       = sat_reg;
        q_pop          = 1'b0;
        mul_start      = 1'b0;
        out_load       = 1'b0;
        rnd_req        = 1'b0;
        rnd_ret        = S_IDLE;
        mul_req        = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        mul_ret        = S_IDLE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.action == ACT_LOAD)
                    begin
                        seed_next = q_item.seed;
                    end
                    else
                    begin
                        rnd_req = 1'b1;
                        rnd_ret = S_SPLIT;
                    end
                end
            end
            S_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (!mul_busy)
                begin
                    state_next = mret_reg;
                end
            end
            S_LCG:
            begin
                seed_next  = lcg_val;
                uni_next   = lcg_val;
                state_next = uret_reg;
            end
            S_SPLIT:
            begin
                neg_next = (uni_reg > HALF_48);
                if (idx_split != '0)
                begin
                    idx_next   = idx_split;
                    star_next  = frac;
                    base_next  = ROM_BASE[idx_split - 5'd1];
                    state_next = S_C_CHECK;
                end
                else
                begin
                    idx_next   = IDX_TAIL;
                    tu_next    = {tu0, 1'b0};
                    base_next  = ROM_BASE[TABLE_ENTRIES - 1];
                    state_next = S_T_DBL;
                end
            end
            // Center interval: linear part above the cut, rejection below it.
            S_C_CHECK:
            begin
                if ({8'd0, star_reg} > ROM_CUT[im1])
                begin
                    mul_req = 1'b1;
                    mul_a   = {8'd0, star_reg} - ROM_CUT[im1];
                    mul_b   = ROM_SLOPE[im1][47:0];
                    mul_ret = S_C_SLOPE;
                end
                else
                begin
                    rnd_req = 1'b1;
                    rnd_ret = S_C_U;
                end
            end
            S_C_SLOPE:
            begin
                mul_req = 1'b1;
                mul_a   = base_reg + pf;
                mul_b   = {16'd0, spread};
                mul_ret = S_SCALE;
            end
            S_C_U:
            begin
                mul_req = 1'b1;
                mul_a   = {8'd0, uni_reg};
                mul_b   = 48'(ROM_BASE[idx_reg] - base_reg);
                mul_ret = S_C_WID;
            end
            S_C_WID:
            begin
                wid_next = pw;
                mul_req  = 1'b1;
                mul_a    = {8'd0, (pw >> 1)} + base_reg;
                mul_b    = pw;
                mul_ret  = S_C_LIM;
            end
            S_C_LIM:
            begin
                lim_next   = pf;
                state_next = S_C_CHAIN;
            end
            S_C_CHAIN:
            begin
                if ({8'd0, star_reg} > lim_reg)
                begin
                    mul_req = 1'b1;
                    mul_a   = y_sum;
                    mul_b   = {16'd0, spread};
                    mul_ret = S_SCALE;
                end
                else
                begin
                    rnd_req = 1'b1;
                    rnd_ret = S_C_V;
                end
            end
            S_C_V:
            begin
                rnd_req = 1'b1;
                if (star_reg >= uni_reg)
                begin
                    lim_next = {8'd0, uni_reg};
                    rnd_ret  = S_C_STAR_KEEP;
                end
                else
                begin
                    rnd_ret = S_C_STAR_NEW;
                end
            end
            S_C_STAR_KEEP:
            begin
                star_next  = uni_reg;
                state_next = S_C_CHAIN;
            end
            S_C_STAR_NEW:
            begin
                star_next  = uni_reg;
                state_next = S_C_CHECK;
            end
            // Tail: one doubling of the fraction per cycle.
            S_T_DBL:
            begin
                if (!tu_reg[48])
                begin
                    base_next = base_reg + ROM_STEP[im1];
                    if (idx_reg < IDX_LAST)
                    begin
                        idx_next = idx_reg + 5'd1;
                    end
                    tu_next = {tu_reg[47:0], 1'b0};
                end
                else
                begin
                    tu_next    = {1'b0, tu_reg[47:0]};
                    state_next = S_T_MUL;
                end
            end
            S_T_MUL:
            begin
                mul_req = 1'b1;
                mul_a   = {8'd0, tu_reg[47:0]};
                mul_b   = ROM_STEP[im1][47:0];
                mul_ret = S_T_WID;
            end
            S_T_WID:
            begin
                wid_next = pw;
                mul_req  = 1'b1;
                mul_a    = {8'd0, (pw >> 1)} + base_reg;
                mul_b    = pw;
                mul_ret  = S_T_LIM;
            end
            S_T_LIM:
            begin
                lim_next   = pf;
                state_next = S_T_CHAIN;
            end
            S_T_CHAIN:
            begin
                rnd_req = 1'b1;
                rnd_ret = S_T_STAR;
            end
            S_T_STAR:
            begin
                star_next = uni_reg;
                if ({8'd0, uni_reg} > lim_reg)
                begin
                    mul_req = 1'b1;
                    mul_a   = y_sum;
                    mul_b   = {16'd0, spread};
                    mul_ret = S_SCALE;
                end
                else
                begin
                    rnd_req = 1'b1;
                    rnd_ret = S_T_TU;
                end
            end
            S_T_TU:
            begin
                rnd_req = 1'b1;
                if (star_reg >= uni_reg)
                begin
                    lim_next = {8'd0, uni_reg};
                    rnd_ret  = S_T_STAR;
                end
                else
                begin
                    rnd_ret = S_T_TU2;
                end
            end
            S_T_TU2:
            begin
                tu_next    = {1'b0, uni_reg};
                state_next = S_T_MUL;
            end
            // Sign, offset and saturation.
            S_SCALE:
            begin
                if (sum > 58'sd2147483647)
                begin
                    res_next = 32'h7FFF_FFFF;
                    sat_next = 1'b1;
                end
                else if (sum < -58'sd2147483648)
                begin
                    res_next = 32'h8000_0000;
                    sat_next = 1'b1;
                end
                else
                begin
                    res_next = sum[31:0];
                    sat_next = 1'b0;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Uniform requests run the generator update through the multiplier.
        if (rnd_req)
        begin
            opa_next   = {8'd0, seed_next};
            opb_next   = LCG_MUL;
            mret_next  = S_LCG;
            uret_next  = rnd_ret;
            state_next = S_MUL_GO;
        end
        if (mul_req)
        begin
            opa_next   = mul_a;
            opb_next   = mul_b;
            mret_next  = mul_ret;
            state_next = S_MUL_GO;
        end
    end

    // Output register valid.
    always_comb
    begin
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mret_reg      <= S_IDLE;
            uret_reg      <= S_IDLE;
            seed_reg      <= SEED_DEFAULT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mret_reg      <= mret_next;
            uret_reg      <= uret_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        uni_reg  <= uni_next;
        star_reg <= star_next;
        lim_reg  <= lim_next;
        base_reg <= base_next;
        wid_reg  <= wid_next;
        tu_reg   <= tu_next;
        idx_reg  <= idx_next;
        neg_reg  <= neg_next;
        opa_reg  <= opa_next;
        opb_reg  <= opb_next;
        res_reg  <= res_next;
        sat_reg  <= sat_next;
        if (out_load)
        begin
            sample_reg    <= res_reg;
            saturated_reg <= sat_reg;
        end
    end

endmodule

// File: rtl/gaussian_deviate_generator.sv
// Top level: configuration registers, input queue and FL5 execution part.
// A reseed is written to the generator state when the execution part takes it from the queue; a
// draw runs its uniforms and products one after another on the shared 56x48 multiplier, and each
// tail doubling and each control step is a state of its own.
// The execution part handles one item at a time; the 2-entry queue keeps accepting, until it is
// full, while the execution part works.
// Reset: generator state 0x1234ABCD330E, mean 0, spread 1.0, queue and output empty.
`timescale 1ns / 1ps

module gaussian_deviate_generator
    import gdg_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [47:0] seed_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sample,
    output logic        saturated,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic        q_valid;
    gdg_item_t   q_item;
    logic        q_pop;
    logic [31:0] mean_reg;
    logic [31:0] spread_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg   <= '0;
            spread_reg <= SPREAD_DEFAULT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MEAN:   mean_reg   <= cfg_data;
                REG_SPREAD: spread_reg <= cfg_data;
                default:    mean_reg   <= mean_reg;
            endcase
        end
    end

    gdg_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .seed_value (seed_value),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    gdg_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .mean_value (mean_reg),
        .spread     (spread_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample     (sample),
        .saturated  (saturated)
    );

endmodule

// File: test/testbench.sv
// Self-checking testbench for the Gaussian deviate generator.
`timescale 1ns / 1ps

module testbench;
    import gdg_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int RANDOM_ITEMS = 450;
    localparam int DIRECTED_ROWS = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [47:0] seed_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] sample;
    logic        saturated;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    // Predictor state.
    logic [47:0] lcg_state;
    logic [31:0] mean_reg;
    logic [31:0] spread_reg;

    typedef struct packed {
        logic [31:0] value;
        logic        clipped;
    } deviate_t;

    deviate_t    deviate_queue[$];
    int          error_count;
    int          cycle_count;
    bit          stall_enable;
    int          hold_cycles;
    bit          idle_free;

    // Directed stimulus rows, each with the settings it runs under.
    typedef struct {
        logic        act;
        logic [47:0] seed;
        logic [31:0] mean;
        logic [31:0] spread;
        bit          typed;
        logic [31:0] exp_value;
        logic        exp_clip;
    } row_t;

    gaussian_deviate_generator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .seed_value (seed_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample     (sample),
        .saturated  (saturated),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [47:0] lcg_next();
        logic [95:0] prod;
        prod = {48'd0, LCG_MUL} * {48'd0, lcg_state} + 96'd11;
        lcg_state = prod[47:0];
        return lcg_state;
    endfunction

    // Product of two 48-bit fractions, truncated.
    function automatic logic [63:0] fix_mul(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[111:48];
    endfunction

    function automatic logic [63:0] center_magnitude(input int idx, input logic [63:0] star_in);
        logic [63:0] base;
        logic [63:0] star;
        logic [63:0] cut;
        logic [63:0] wid;
        logic [63:0] lim;
        logic [63:0] v;
        bit          done;
        bit          accept;
        base = 64'(ROM_BASE[idx-1]);
        star = star_in;
        forever
        begin
            cut = 64'(ROM_CUT[idx-1]);
            if (star > cut)
                return base + fix_mul(star - cut, 64'(ROM_SLOPE[idx-1]));
            wid = fix_mul(64'(lcg_next()), 64'(ROM_BASE[idx]) - base);
            lim = fix_mul((wid >> 1) + base, wid);
            done = 0;
            accept = 0;
            while (!done)
            begin
                if (star > lim)
                begin
                    accept = 1;
                    done = 1;
                end
                else
                begin
                    v = 64'(lcg_next());
                    if (star >= v)
                    begin
                        lim = v;
                        star = 64'(lcg_next());
                    end
                    else
                    begin
                        star = 64'(lcg_next());
                        done = 1;
                    end
                end
            end
            if (accept)
                return base + wid;
        end
    endfunction

    function automatic logic [63:0] tail_magnitude(input logic [63:0] tu_in);
        logic [63:0] one;
        logic [63:0] base;
        logic [63:0] tu;
        logic [63:0] wid;
        logic [63:0] lim;
        logic [63:0] star;
        int          idx;
        bit          restart;
        one = 64'd1 << 48;
        idx = 6;
        base = 64'(ROM_BASE[TABLE_ENTRIES-1]);
        tu = (tu_in == 0) ? 64'd32 : tu_in;
        tu = tu << 1;
        while (tu < one)
        begin
            base = base + 64'(ROM_STEP[idx-1]);
            if (idx < TABLE_ENTRIES - 1)
                idx++;
            tu = tu << 1;
        end
        tu = tu - one;
        forever
        begin
            wid = fix_mul(tu, 64'(ROM_STEP[idx-1]));
            lim = fix_mul((wid >> 1) + base, wid);
            restart = 0;
            while (!restart)
            begin
                star = 64'(lcg_next());
                if (star > lim)
                    return base + wid;
                tu = 64'(lcg_next());
                if (star >= tu)
                    lim = tu;
                else
                begin
                    tu = 64'(lcg_next());
                    restart = 1;
                end
            end
        end
    endfunction

    // Applies one accepted transaction to the predictor.
    task automatic predict_deviate(input logic act, input logic [47:0] seed);
        logic [63:0] uni;
        logic [63:0] dbl;
        logic [63:0] frac;
        logic [63:0] mag;
        logic [63:0] z;
        logic signed [65:0] total;
        int          idx;
        bit          neg;
        deviate_t    d;
        if (act == ACT_LOAD)
        begin
            lcg_state = seed;
            return;
        end
        uni = 64'(lcg_next());
        neg = uni > (64'd1 << 47);
        dbl = neg ? (2 * uni - (64'd1 << 48)) : 2 * uni;
        idx = int'(dbl >> 43);
        if (idx > TABLE_ENTRIES - 1)
            idx = TABLE_ENTRIES - 1;
        frac = (dbl << 5) & 64'hFFFF_FFFF_FFFF;
        z = (idx != 0) ? center_magnitude(idx, frac) : tail_magnitude(frac);
        mag = fix_mul(64'(spread_reg), z);
        total = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        total = total + 66'(signed'(mean_reg));
        d.clipped = 1'b0;
        if (total > 66'sd2147483647)
        begin
            total = 66'sd2147483647;
            d.clipped = 1'b1;
        end
        else if (total < -66'sd2147483648)
        begin
            total = -66'sd2147483648;
            d.clipped = 1'b1;
        end
        d.value = total[31:0];
        deviate_queue.push_back(d);
    endtask

    // Output checker and receiver stall.
    always @(posedge clk)
    begin
        deviate_t d;
        if (rst_n && out_valid && !out_stall)
        begin
            if (deviate_queue.size() == 0)
            begin
                $display("%0t: unexpected result sample=%h saturated=%b",
                         $time, sample, saturated);
                error_count++;
            end
            else
            begin
                d = deviate_queue.pop_front();
                if (sample !== d.value)
                begin
                    $display("%0t: sample expected %h actual %h", $time, d.value, sample);
                    error_count++;
                end
                if (saturated !== d.clipped)
                begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, d.clipped, saturated);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= stall_enable && !idle_free && ($urandom_range(99) < 15);
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_register(input logic idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MEAN)
            mean_reg = value;
        else
            spread_reg = value;
    endtask

    // Sends one transaction; the predictor is updated at acceptance.
    // Valid stays high afterward so that transactions can follow back to back.
    task automatic send_transaction(input logic act, input logic [47:0] seed);
        while (!idle_free && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        seed_value <= seed;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_deviate(act, seed);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (deviate_queue.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    row_t rows[DIRECTED_ROWS];

    initial
    begin
        logic        act;
        logic [47:0] seed;
        logic [31:0] m;
        error_count = 0;
        cycle_count = 0;
        stall_enable = 0;
        hold_cycles = 0;
        idle_free = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_DRAW;
        seed_value = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MEAN;
        cfg_data = '0;
        lcg_state = SEED_DEFAULT;
        mean_reg = '0;
        spread_reg = SPREAD_DEFAULT;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: reseeds at the extremes and with alternating patterns, draws with defaults.
        rows[0]  = '{ACT_DRAW, 48'd0, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[1]  = '{ACT_DRAW, 48'd0, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[2]  = '{ACT_LOAD, 48'd0, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[3]  = '{ACT_DRAW, 48'd0, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[4]  = '{ACT_LOAD, 48'hFFFF_FFFF_FFFF, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[5]  = '{ACT_DRAW, 48'd0, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[6]  = '{ACT_LOAD, 48'hAAAA_AAAA_AAAA, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[7]  = '{ACT_DRAW, 48'h5555_5555_5555, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[8]  = '{ACT_LOAD, 48'h5555_5555_5555, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[9]  = '{ACT_DRAW, 48'hFFFF_FFFF_FFFF, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[10] = '{ACT_DRAW, 48'd0, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[11] = '{ACT_DRAW, 48'd0, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[12] = '{ACT_LOAD, 48'h1234_ABCD_330E, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        rows[13] = '{ACT_DRAW, 48'd0, 32'd0, SPREAD_DEFAULT, 0, 32'd0, 1'b0};
        // Zero spread gives exactly the mean; maximal mean with huge spread can clip on the high side.
        rows[14] = '{ACT_DRAW, 48'd0, 32'h8000_0000, 32'd0, 1, 32'h8000_0000, 1'b0};
        rows[15] = '{ACT_DRAW, 48'd0, 32'h7FFF_FFFF, 32'd0, 1, 32'h7FFF_FFFF, 1'b0};
        rows[16] = '{ACT_DRAW, 48'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 32'd0, 1'b0};
        rows[17] = '{ACT_DRAW, 48'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 32'd0, 1'b0};
        rows[18] = '{ACT_DRAW, 48'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 32'd0, 1'b0};
        rows[19] = '{ACT_DRAW, 48'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 32'd0, 1'b0};
        foreach (rows[i])
        begin
            if (rows[i].mean != mean_reg || rows[i].spread != spread_reg)
            begin
                wait_drain();
                write_register(REG_MEAN, rows[i].mean);
                write_register(REG_SPREAD, rows[i].spread);
            end
            send_transaction(rows[i].act, rows[i].seed);
            // Typed rows are checked against the typed value.
            if (rows[i].typed)
            begin
                if (deviate_queue[$].value !== rows[i].exp_value ||
                    deviate_queue[$].clipped !== rows[i].exp_clip)
                begin
                    $display("%0t: row %0d expected %h/%b actual prediction %h/%b",
                             $time, i, rows[i].exp_value, rows[i].exp_clip,
                             deviate_queue[$].value, deviate_queue[$].clipped);
                    error_count++;
                end
                deviate_queue[$] = '{value: rows[i].exp_value, clipped: rows[i].exp_clip};
            end
        end
        wait_drain();

        // Random phases over several settings, with stalls enabled in all but phase 4.
        stall_enable = 1;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: m = 32'd0;
                1: m = 32'h8000_0000;
                2: m = 32'h7FFF_FFFF;
                default: m = $urandom;
            endcase
            write_register(REG_MEAN, m);
            case (phase)
                0: write_register(REG_SPREAD, SPREAD_DEFAULT);
                1: write_register(REG_SPREAD, 32'hFFFF_FFFF);
                2: write_register(REG_SPREAD, 32'd0);
                3: write_register(REG_SPREAD, $urandom_range(32'h0100_0000));
                default: write_register(REG_SPREAD, $urandom);
            endcase
            if (phase == 1)
                hold_cycles = 300;
            idle_free = (phase == 4);
            for (int n = 0; n < RANDOM_ITEMS / 6; n++)
            begin
                act = ($urandom_range(99) < 10) ? ACT_LOAD : ACT_DRAW;
                seed = 48'({$urandom, $urandom});
                send_transaction(act, seed);
            end
            wait_drain();
        end

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
